/* src/bbf_pkg.sv */
// Package: shared constants and types of the bit buffer FIFO.
package bbf_pkg;

    localparam int CAP_BYTES = 512;
    localparam int CAP_BITS  = CAP_BYTES * 8;
    localparam int ADDR_W    = (CAP_BYTES > 1) ? $clog2(CAP_BYTES) : 1;
    localparam int POS_W     = $clog2(CAP_BITS + 1);
    localparam int SIZE_W    = 13;
    localparam int OCC_W     = 10;

    typedef enum logic [1:0] {
        REQ_WR_BIT  = 2'd0,
        REQ_WR_BYTE = 2'd1,
        REQ_RD_BIT  = 2'd2,
        REQ_CLEAR   = 2'd3
    } t_req;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

endpackage

/* src/bit_buffer_fifo.sv */
// Top level: linear bit buffer with a byte-wide store and a partial-byte tail register.
//
// Usage:
//   Input channel  (i_valid / o_ready): one request per transaction, i_req_type
//   selects write bit, write byte (LSB first at the current bit offset), read
//   bit, or clear; i_wr_data carries the byte (bit 0 for a bit write).
//   Output channel (o_valid / i_ready): exactly one result per request with the
//   bit read, its valid flag, the overflow flag, unread bits and unread bytes.
//   Each request is registered when taken and executed in the execute state,
//   which loads the result register and so raises o_valid.
//   Requests are taken only in the idle state, none before the last has executed;
//   the byte store is a synchronous memory, read in the accept cycle and
//   consumed in the execute cycle. Completed bytes are written to the store;
//   the byte under the write position stays in a tail register.
//   Space that has been read is reused only after a clear request.
//   Reset: both bit positions return to zero and the result register empties;
//   the store keeps its contents and needs no clearing pass.
//   Stall: while a result is not taken the next request is still accepted
//   but holds in the execute cycle; no result is lost or repeated.
module bit_buffer_fifo (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_req_type,
    input  logic [7:0]                i_wr_data,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_rd_bit,
    output logic                      o_rd_ok,
    output logic                      o_overflow,
    output logic [bbf_pkg::SIZE_W-1:0] o_size_bits,
    output logic [bbf_pkg::OCC_W-1:0]  o_occupancy_bytes
);

    localparam int PW = bbf_pkg::POS_W;
    localparam int AW = bbf_pkg::ADDR_W;
    localparam int IW = PW - 3;

    // Byte store
    logic [7:0] mem [bbf_pkg::CAP_BYTES];
    logic [7:0] mem_q;
    logic       mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0] mem_wdata;
    logic       mem_re;

    // Control and datapath registers
    bbf_pkg::t_state r_state, n_state;
    logic [PW-1:0] r_wpos, n_wpos;
    logic [PW-1:0] r_rpos, n_rpos;
    logic [7:0]    r_tail, n_tail;
    bbf_pkg::t_req r_req;
    logic [7:0]    r_data;
    logic          r_out_valid, n_out_valid;
    logic          r_rd_bit, n_rd_bit;
    logic          r_rd_ok, n_rd_ok;
    logic          r_ovf, n_ovf;
    logic [bbf_pkg::SIZE_W-1:0] r_size, n_size;
    logic [bbf_pkg::OCC_W-1:0]  r_occ, n_occ;

    logic          in_fire;
    logic          done;
    logic [2:0]    wsh, rsh;
    logic [IW-1:0] widx, ridx;
    logic [7:0]    low_mask, keep, rbyte;
    logic [15:0]   merged;
    logic [PW:0]   wpos_p8;
    logic [PW-1:0] size_pos;
    logic [PW:0]   size_p7;

    assign o_ready = (r_state == bbf_pkg::ST_IDLE);
    assign in_fire = i_valid && o_ready;
    assign mem_re  = in_fire;
    assign done    = (r_state == bbf_pkg::ST_EXEC) && (!r_out_valid || i_ready);

    assign wsh      = r_wpos[2:0];
    assign rsh      = r_rpos[2:0];
    assign widx     = r_wpos[PW-1:3];
    assign ridx     = r_rpos[PW-1:3];
    assign low_mask = ~(8'hFF << wsh);
    assign keep     = r_tail & low_mask;
    assign merged   = {8'h00, keep} | ({8'h00, r_data} << wsh);
    assign wpos_p8  = {1'b0, r_wpos} + (PW+1)'(8);

    // Write and read the byte store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_q <= mem[ridx[AW-1:0]];
        end
    end

    // Hold the request and the registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bbf_pkg::ST_IDLE;
            r_wpos      <= '0;
            r_rpos      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wpos      <= n_wpos;
            r_rpos      <= n_rpos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_req  <= bbf_pkg::t_req'(i_req_type);
            r_data <= i_wr_data;
        end
        r_tail   <= n_tail;
        r_rd_bit <= n_rd_bit;
        r_rd_ok  <= n_rd_ok;
        r_ovf    <= n_ovf;
        r_size   <= n_size;
        r_occ    <= n_occ;
    end

    // Execute the request and load the result register
    always_comb begin
        n_state     = r_state;
        n_wpos      = r_wpos;
        n_rpos      = r_rpos;
        n_tail      = r_tail;
        n_out_valid = r_out_valid;
        n_rd_bit    = r_rd_bit;
        n_rd_ok     = r_rd_ok;
        n_ovf       = r_ovf;
        n_size      = r_size;
        n_occ       = r_occ;
        mem_we      = 1'b0;
        mem_waddr   = widx[AW-1:0];
        mem_wdata   = merged[7:0];
        rbyte       = (ridx == widx) ? r_tail : mem_q;
        size_pos    = '0;
        size_p7     = '0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            bbf_pkg::ST_IDLE: begin
                if (in_fire) begin
                    n_state = bbf_pkg::ST_EXEC;
                end
            end
            bbf_pkg::ST_EXEC: begin
                if (done) begin
                    n_state  = bbf_pkg::ST_IDLE;
                    n_rd_bit = 1'b0;
                    n_rd_ok  = 1'b0;
                    n_ovf    = 1'b0;
                    case (r_req)
                        bbf_pkg::REQ_WR_BIT: begin
                            if (r_wpos < PW'(bbf_pkg::CAP_BITS)) begin
                                n_tail = keep | ({7'd0, r_data[0]} << wsh);
                                if (wsh == 3'd7) begin
                                    mem_we    = 1'b1;
                                    mem_wdata = n_tail;
                                end
                                n_wpos = r_wpos + PW'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        bbf_pkg::REQ_WR_BYTE: begin
                            if (wpos_p8 <= (PW+1)'(bbf_pkg::CAP_BITS)) begin
                                mem_we = 1'b1;
                                n_tail = merged[15:8];
                                n_wpos = wpos_p8[PW-1:0];
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        bbf_pkg::REQ_RD_BIT: begin
                            if (r_rpos < r_wpos) begin
                                n_rd_bit = rbyte[rsh];
                                n_rd_ok  = 1'b1;
                                n_rpos   = r_rpos + PW'(1);
                            end
                        end
                        bbf_pkg::REQ_CLEAR: begin
                            n_wpos = '0;
                            n_rpos = '0;
                        end
                        default: begin
                            n_wpos = r_wpos;
                        end
                    endcase
                    size_pos    = n_wpos - n_rpos;
                    size_p7     = {1'b0, size_pos} + (PW+1)'(7);
                    n_size      = bbf_pkg::SIZE_W'(size_pos);
                    n_occ       = bbf_pkg::OCC_W'(size_p7 >> 3);
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = bbf_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_valid           = r_out_valid;
    assign o_rd_bit          = r_rd_bit;
    assign o_rd_ok           = r_rd_ok;
    assign o_overflow        = r_ovf;
    assign o_size_bits       = r_size;
    assign o_occupancy_bytes = r_occ;

    // Read position never passes the write position
    a_rpos_le_wpos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rpos <= r_wpos)
        else $error("read position passed write position");

    // Write position stays within capacity
    a_wpos_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wpos <= PW'(bbf_pkg::CAP_BITS))
        else $error("write position beyond capacity");

    // A read result never carries an overflow
    a_rd_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_rd_ok && o_overflow))
        else $error("read and overflow flagged together");

    // The execute state is not left before the request completes
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bbf_pkg::ST_EXEC && !done) |=> (r_state == bbf_pkg::ST_EXEC))
        else $error("execute cycle left without completing");

    // A completed request always presents a result
    a_done_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> o_valid)
        else $error("completed request gave no result");

endmodule

/* sim/bit_buffer_fifo_test.sv */
// Testbench: random and directed request traffic for bit_buffer_fifo against a shadow buffer.
module bit_buffer_fifo_test;

    typedef struct {
        bbf_pkg::t_req req;
        logic [7:0]    data;
        bit            wait_empty;
    } t_buf_request;

    typedef struct {
        logic                       rd_bit;
        logic                       rd_ok;
        logic                       overflow;
        logic [bbf_pkg::SIZE_W-1:0] size_bits;
        logic [bbf_pkg::OCC_W-1:0]  occ_bytes;
    } t_buf_response;

    localparam int TARGET_ITEMS   = 1675;
    localparam int STALL_LIMIT    = 2000;
    localparam int HOLD_AT        = 200;
    localparam int HOLD_CYCLES    = 400;
    localparam int STEADY_FROM    = 1000;
    localparam int STEADY_TO      = 1250;
    localparam int GAP_PERCENT    = 37;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_ready;
    logic [1:0]                 i_req_type;
    logic [7:0]                 i_wr_data;
    logic                       o_valid;
    logic                       i_ready;
    logic                       o_rd_bit;
    logic                       o_rd_ok;
    logic                       o_overflow;
    logic [bbf_pkg::SIZE_W-1:0] o_size_bits;
    logic [bbf_pkg::OCC_W-1:0]  o_occupancy_bytes;

    // Stimulus and scoreboard storage
    t_buf_request  pending_requests[$];
    t_buf_response expected_responses[$];
    int            total_items;

    // Shadow copy of the buffer
    logic [7:0]  shadow_bytes [bbf_pkg::CAP_BYTES];
    int unsigned wr_pos;
    int unsigned rd_pos;

    // Position tracking used only while the stimulus is planned
    int unsigned plan_wr;
    int unsigned plan_rd;

    // Handshake bookkeeping of the clocked processes
    bit  in_taken;
    int  items_taken;
    int  responses_seen;
    int  mismatches;
    int  idle_cycles;
    int  hold_left;
    bit  hold_done;

    // Run statistics
    int  bits_read;
    int  empty_reads;
    int  dropped_writes;
    int  clears;
    int  peak_unread;

    bit_buffer_fifo uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_req_type        (i_req_type),
        .i_wr_data         (i_wr_data),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_rd_bit          (o_rd_bit),
        .o_rd_ok           (o_rd_ok),
        .o_overflow        (o_overflow),
        .o_size_bits       (o_size_bits),
        .o_occupancy_bytes (o_occupancy_bytes)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Apply one request to the shadow buffer and return the response it should give
    function automatic t_buf_response predict_buffer_response(bbf_pkg::t_req req,
                                                              logic [7:0] data);
        t_buf_response resp;
        int unsigned   unread;
        int unsigned   occ;
        int            i;
        resp.rd_bit   = 1'b0;
        resp.rd_ok    = 1'b0;
        resp.overflow = 1'b0;
        case (req)
            bbf_pkg::REQ_WR_BIT: begin
                if (wr_pos + 1 > bbf_pkg::CAP_BITS) begin
                    resp.overflow = 1'b1;
                    dropped_writes++;
                end else begin
                    shadow_bytes[wr_pos / 8][wr_pos % 8] = data[0];
                    wr_pos++;
                end
            end
            bbf_pkg::REQ_WR_BYTE: begin
                if (wr_pos + 8 > bbf_pkg::CAP_BITS) begin
                    resp.overflow = 1'b1;
                    dropped_writes++;
                end else begin
                    // Store LSB first starting at the current bit offset
                    for (i = 0; i < 8; i++)
                        shadow_bytes[(wr_pos + i) / 8][(wr_pos + i) % 8] = data[i];
                    wr_pos += 8;
                end
            end
            bbf_pkg::REQ_RD_BIT: begin
                if (rd_pos < wr_pos) begin
                    resp.rd_bit = shadow_bytes[rd_pos / 8][rd_pos % 8];
                    resp.rd_ok  = 1'b1;
                    rd_pos++;
                    bits_read++;
                end else begin
                    empty_reads++;
                end
            end
            default: begin
                wr_pos = 0;
                rd_pos = 0;
                clears++;
            end
        endcase
        unread         = wr_pos - rd_pos;
        occ            = (unread + 7) >> 3;
        resp.size_bits = unread[bbf_pkg::SIZE_W-1:0];
        resp.occ_bytes = occ[bbf_pkg::OCC_W-1:0];
        if (unread > peak_unread)
            peak_unread = unread;
        return resp;
    endfunction

    // Queue one request and advance the planning positions
    task automatic add_request(bbf_pkg::t_req req, logic [7:0] data, bit wait_empty);
        t_buf_request item;
        item.req         = req;
        item.data        = data;
        item.wait_empty  = wait_empty;
        pending_requests = {pending_requests, item};
        case (req)
            bbf_pkg::REQ_WR_BIT:  if (plan_wr + 1 <= bbf_pkg::CAP_BITS) plan_wr += 1;
            bbf_pkg::REQ_WR_BYTE: if (plan_wr + 8 <= bbf_pkg::CAP_BITS) plan_wr += 8;
            bbf_pkg::REQ_RD_BIT:  if (plan_rd < plan_wr) plan_rd += 1;
            default: begin
                plan_wr = 0;
                plan_rd = 0;
            end
        endcase
    endtask

    // Fill the buffer to the last bit, push past it, then read a little back
    task automatic fill_to_capacity();
        int pick;
        int room;
        add_request(bbf_pkg::REQ_CLEAR, 8'($urandom_range(255)), 1'b1);
        while (bbf_pkg::CAP_BITS - plan_wr >= 8) begin
            pick = $urandom_range(99);
            if (pick < 85)
                add_request(bbf_pkg::REQ_WR_BYTE, 8'($urandom_range(255)), 1'b0);
            else if (pick < 95)
                add_request(bbf_pkg::REQ_WR_BIT, 8'($urandom_range(255)), 1'b0);
            else
                add_request(bbf_pkg::REQ_RD_BIT, 8'($urandom_range(255)), 1'b0);
        end
        room = bbf_pkg::CAP_BITS - plan_wr;
        // A byte that does not fit in the last few free bits is dropped whole
        if (room > 0)
            add_request(bbf_pkg::REQ_WR_BYTE, 8'($urandom_range(255)), 1'b0);
        repeat (room)
            add_request(bbf_pkg::REQ_WR_BIT, 8'($urandom_range(255)), 1'b0);
        repeat (2)
            add_request(bbf_pkg::REQ_WR_BIT, 8'($urandom_range(255)), 1'b0);
        add_request(bbf_pkg::REQ_WR_BYTE, 8'($urandom_range(255)), 1'b0);
        repeat ($urandom_range(30, 80))
            add_request(bbf_pkg::REQ_RD_BIT, 8'($urandom_range(255)), 1'b0);
    endtask

    // Short mixed burst, then drain to empty when little is left
    task automatic mixed_traffic();
        int pick;
        int unread;
        if (plan_wr - plan_rd > 200 || plan_wr > bbf_pkg::CAP_BITS - 64
            || $urandom_range(1) == 1)
            add_request(bbf_pkg::REQ_CLEAR, 8'($urandom_range(255)), 1'b0);
        repeat ($urandom_range(10, 40)) begin
            pick = $urandom_range(99);
            if (pick < 30)
                add_request(bbf_pkg::REQ_WR_BYTE, 8'($urandom_range(255)), 1'b0);
            else if (pick < 55)
                add_request(bbf_pkg::REQ_WR_BIT, 8'($urandom_range(255)), 1'b0);
            else if (pick < 97)
                add_request(bbf_pkg::REQ_RD_BIT, 8'($urandom_range(255)), 1'b0);
            else
                add_request(bbf_pkg::REQ_CLEAR, 8'($urandom_range(255)), 1'b0);
        end
        unread = plan_wr - plan_rd;
        if (unread <= 48)
            repeat (unread + $urandom_range(1, 3))
                add_request(bbf_pkg::REQ_RD_BIT, 8'($urandom_range(255)), 1'b0);
    endtask

    // Compare one response field and log a mismatch
    task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    // Score responses, then record accepted requests into the shadow buffer
    always @(posedge i_clk) begin : response_monitor
        t_buf_response want;
        t_buf_response next_want;
        if (!i_rst_n) begin
            in_taken = 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                responses_seen++;
                if (expected_responses.size() == 0) begin
                    $display("%0t: response with none pending, expected nothing, actual size %0d",
                             $time, o_size_bits);
                    mismatches++;
                end else begin
                    want = expected_responses.pop_front();
                    check_field("rd_bit", 16'(want.rd_bit), 16'(o_rd_bit));
                    check_field("rd_ok", 16'(want.rd_ok), 16'(o_rd_ok));
                    check_field("overflow", 16'(want.overflow), 16'(o_overflow));
                    check_field("size_bits", 16'(want.size_bits), 16'(o_size_bits));
                    check_field("occupancy_bytes", 16'(want.occ_bytes),
                                16'(o_occupancy_bytes));
                end
            end
            in_taken = i_valid && o_ready;
            if (in_taken) begin
                next_want = predict_buffer_response(bbf_pkg::t_req'(i_req_type), i_wr_data);
                expected_responses = {expected_responses, next_want};
                items_taken++;
            end
        end
    end

    // Offer requests from the pending queue with random gaps, none in the steady window
    always @(negedge i_clk) begin : request_driver
        t_buf_request item;
        logic         next_valid;
        bit           steady;
        next_valid = i_valid;
        steady     = items_taken >= STEADY_FROM && items_taken < STEADY_TO;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else begin
            if (i_valid && in_taken)
                next_valid = 1'b0;
            // Hold a request marked to wait until every response is back
            if (!next_valid && pending_requests.size() > 0
                && (!pending_requests[0].wait_empty || expected_responses.size() == 0)
                && (steady || $urandom_range(99) >= GAP_PERCENT)) begin
                item = pending_requests.pop_front();
                i_req_type <= item.req;
                i_wr_data  <= item.data;
                next_valid = 1'b1;
            end
        end
        i_valid <= next_valid;
    end

    // Take responses with random stalls and one long hold-off, with no stalls in the steady window
    always @(negedge i_clk) begin : response_acceptor
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && responses_seen >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_ready   <= 1'b0;
        end else if (responses_seen >= STEADY_FROM && responses_seen < STEADY_TO) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(99) >= GAP_PERCENT);
        end
    end

    // Abort when no transaction moves for too long
    always @(posedge i_clk) begin : stall_watchdog
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
                $display("bit_buffer_fifo verification failed");
                $finish;
            end
        end
    end

    initial begin
        int fills;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_ready        = 1'b0;
        i_req_type     = bbf_pkg::REQ_WR_BIT;
        i_wr_data      = 8'h00;
        wr_pos         = 0;
        rd_pos         = 0;
        plan_wr        = 0;
        plan_rd        = 0;
        in_taken       = 1'b0;
        items_taken    = 0;
        responses_seen = 0;
        mismatches     = 0;
        idle_cycles    = 0;
        hold_left      = 0;
        hold_done      = 1'b0;
        bits_read      = 0;
        empty_reads    = 0;
        dropped_writes = 0;
        clears         = 0;
        peak_unread    = 0;
        fills          = 0;

        // Directed: empty read, ignored upper bits, bytes at unaligned offsets, clear
        add_request(bbf_pkg::REQ_RD_BIT, 8'hFF, 1'b0);
        add_request(bbf_pkg::REQ_WR_BIT, 8'hFE, 1'b0);
        add_request(bbf_pkg::REQ_WR_BIT, 8'h01, 1'b0);
        add_request(bbf_pkg::REQ_WR_BYTE, 8'hA5, 1'b0);
        add_request(bbf_pkg::REQ_WR_BYTE, 8'h5A, 1'b0);
        add_request(bbf_pkg::REQ_WR_BYTE, 8'hFF, 1'b0);
        add_request(bbf_pkg::REQ_WR_BYTE, 8'h00, 1'b0);
        repeat (6)
            add_request(bbf_pkg::REQ_RD_BIT, 8'h00, 1'b0);
        add_request(bbf_pkg::REQ_CLEAR, 8'hFF, 1'b0);
        add_request(bbf_pkg::REQ_RD_BIT, 8'h00, 1'b0);
        add_request(bbf_pkg::REQ_WR_BYTE, 8'h81, 1'b0);
        repeat (9)
            add_request(bbf_pkg::REQ_RD_BIT, 8'hFF, 1'b0);

        // Random: two full-capacity fills among mixed bursts
        while (pending_requests.size() < TARGET_ITEMS) begin
            if ((fills == 0) || (fills == 1 && pending_requests.size() >= 1000)) begin
                fill_to_capacity();
                fills++;
            end else begin
                mixed_traffic();
            end
        end
        total_items = pending_requests.size();

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (items_taken < total_items)
            @(posedge i_clk);
        while (expected_responses.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Ran %0d requests: %0d bits read, %0d reads on empty, %0d writes dropped",
                 items_taken, bits_read, empty_reads, dropped_writes);
        $display("%0d clears, peak unread bits %0d of %0d, %0d mismatches",
                 clears, peak_unread, bbf_pkg::CAP_BITS, mismatches);
        if (mismatches == 0 && expected_responses.size() == 0)
            $display("bit_buffer_fifo verification clean");
        else
            $display("bit_buffer_fifo verification failed");
        $finish;
    end

endmodule
